### hw/rtl/seven_segment_frame_generator_top_assert.svh
// Assertion helpers for the RTL; sfg_back includes them. All checks run on clk_i and
// are switched off while rst_ni is low.
`ifndef SEVEN_SEGMENT_FRAME_GENERATOR_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfg assertion failed");

`endif

### hw/rtl/sfg_pkg.sv
package sfg_pkg;

  typedef enum logic [1:0] {
    ACT_NUMBER = 2'd0,
    ACT_TIME   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH    = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned BRIGHT_W  = 3;
  localparam int unsigned REFRESH_W = 16;
  localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET  = 3'd7;
  localparam logic [REFRESH_W-1:0] REFRESH_RESET = 16'd1000;
  localparam logic [REFRESH_W-1:0] TICK_MAX      = 16'hFFFF;

  localparam logic [7:0] CMD_DATA     = 8'h40;
  localparam logic [7:0] CMD_ADDR     = 8'hC0;
  localparam logic [7:0] CMD_DISP     = 8'h88;
  localparam logic [7:0] SEG_NEG_SIGN = 8'h40;
  localparam logic [7:0] SEG_COLON    = 8'h80;
  localparam logic [7:0] SEG_BLANK    = 8'h00;

  localparam int unsigned MAG_W = 14;
  localparam logic [15:0] NEG_LIMIT  = 16'd999;
  localparam logic [15:0] POS_LIMIT  = 16'd9999;
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MINUTE_MAX = 8'd59;

  typedef struct packed {
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
  } frame_t;

  typedef struct packed {
    logic             is_num;
    logic             neg;
    logic [MAG_W-1:0] mag;
    frame_t           frame;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       start_before;
    logic       stop_after;
    logic       last_byte;
  } out_t;

  typedef enum logic [2:0] {
    SLOT_DATA_CMD = 3'd0,
    SLOT_ADDR_CMD = 3'd1,
    SLOT_DIG0     = 3'd2,
    SLOT_DIG1     = 3'd3,
    SLOT_DIG2     = 3'd4,
    SLOT_DIG3     = 3'd5,
    SLOT_DISP_CMD = 3'd6
  } slot_e;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } pair_t;

  function automatic logic [7:0] seg_of(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Splits a value below one hundred into two decimal digits.
  function automatic pair_t split_pair(logic [6:0] v);
    pair_t      p;
    logic [3:0] t;
    logic [6:0] r;
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(i * 10)) begin
        t = 4'(i);
      end
    end
    r = v - ({3'b000, t} * 7'd10);
    p.tens = t;
    p.ones = r[3:0];
    return p;
  endfunction

  function automatic frame_t clock_frame(logic [4:0] h, logic [5:0] m);
    frame_t f;
    pair_t  hp;
    pair_t  mp;
    hp = split_pair({2'b00, h});
    mp = split_pair({1'b0, m});
    f.d0 = seg_of(hp.tens);
    f.d1 = seg_of(hp.ones) | SEG_COLON;
    f.d2 = seg_of(mp.tens);
    f.d3 = seg_of(mp.ones);
    return f;
  endfunction

endpackage

### hw/rtl/sfg_front.sv
module sfg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic signed [15:0]             number_value_i,
  input  logic [7:0]                     hour_value_i,
  input  logic [7:0]                     minute_value_i,
  input  logic [sfg_pkg::REFRESH_W-1:0]  refresh_period_i,
  input  logic                           full_i,
  output logic                           push_o,
  output sfg_pkg::frame_t                push_data_o
);
  import sfg_pkg::*;

  logic                 time_shown_q, time_shown_d;
  logic [4:0]           hour_q, hour_d;
  logic [5:0]           minute_q, minute_d;
  logic [REFRESH_W-1:0] ticks_q, ticks_d;

  logic  s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;
  item_t s1_q, s2_q, s3_q, item;
  logic  s1_ready, s2_ready, s3_ready;
  logic  accept, emit;

  action_e              act;
  logic [15:0]          neg_mag;
  logic [15:0]          pos_val;
  logic [REFRESH_W-1:0] tick_next;

  // Thousands digit (or the minus sign of a negative number) by parallel compares, then the remainder.
  function automatic item_t step_thousands(item_t it);
    item_t      o;
    logic [3:0] k;
    o = it;
    k = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (it.mag >= MAG_W'(i * 1000)) begin
        k = 4'(i);
      end
    end
    if (it.is_num) begin
      o.mag      = it.mag - ({10'b0, k} * MAG_W'(1000));
      o.frame.d0 = it.neg ? SEG_NEG_SIGN : seg_of(k);
    end
    return o;
  endfunction

  function automatic item_t step_hundreds(item_t it);
    item_t      o;
    logic [3:0] k;
    o = it;
    k = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (it.mag >= MAG_W'(i * 100)) begin
        k = 4'(i);
      end
    end
    if (it.is_num) begin
      o.mag      = it.mag - ({10'b0, k} * MAG_W'(100));
      o.frame.d1 = seg_of(k);
    end
    return o;
  endfunction

  always_comb begin
    s3_ready   = !s3_v_q || !full_i;
    s2_ready   = !s2_v_q || s3_ready;
    s1_ready   = !s1_v_q || s2_ready;
    in_stall_o = !s1_ready;
    accept     = in_valid_i && s1_ready;
  end

  // Classify the command and update the display state at the transfer.
  always_comb begin
    act       = action_e'(action_i);
    neg_mag   = 16'(-number_value_i);
    pos_val   = 16'(number_value_i);
    tick_next = (ticks_q != TICK_MAX) ? ticks_q + 16'd1 : ticks_q;

    emit         = 1'b0;
    item         = '0;
    time_shown_d = time_shown_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    ticks_d      = ticks_q;

    if (accept) begin
      case (act)
        ACT_NUMBER: begin
          emit         = 1'b1;
          time_shown_d = 1'b0;
          item.is_num  = 1'b1;
          item.neg     = number_value_i[15];
          if (number_value_i[15]) begin
            item.mag = (neg_mag > NEG_LIMIT) ? NEG_LIMIT[MAG_W-1:0] : neg_mag[MAG_W-1:0];
          end else begin
            item.mag = (pos_val > POS_LIMIT) ? POS_LIMIT[MAG_W-1:0] : pos_val[MAG_W-1:0];
          end
        end
        ACT_TIME: begin
          if (hour_value_i <= HOUR_MAX && minute_value_i <= MINUTE_MAX) begin
            emit         = 1'b1;
            time_shown_d = 1'b1;
            hour_d       = hour_value_i[4:0];
            minute_d     = minute_value_i[5:0];
            ticks_d      = '0;
            item.frame   = clock_frame(hour_value_i[4:0], minute_value_i[5:0]);
          end
        end
        ACT_CLEAR: begin
          emit         = 1'b1;
          time_shown_d = 1'b0;
          item.frame   = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_BLANK};
        end
        ACT_TICK: begin
          if (time_shown_q) begin
            if (tick_next >= refresh_period_i) begin
              emit       = 1'b1;
              ticks_d    = '0;
              item.frame = clock_frame(hour_q, minute_q);
            end else begin
              ticks_d = tick_next;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    s1_v_d = s1_ready ? (accept && emit) : s1_v_q;
    s2_v_d = s2_ready ? s1_v_q : s2_v_q;
    s3_v_d = s3_ready ? s2_v_q : s3_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_shown_q <= 1'b0;
      hour_q       <= '0;
      minute_q     <= '0;
      ticks_q      <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
    end else begin
      time_shown_q <= time_shown_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      ticks_q      <= ticks_d;
      s1_v_q       <= s1_v_d;
      s2_v_q       <= s2_v_d;
      s3_v_q       <= s3_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item;
    end
    if (s2_ready) begin
      s2_q <= step_thousands(s1_q);
    end
    if (s3_ready) begin
      s3_q <= step_hundreds(s2_q);
    end
  end

  // Tens and ones are split on the way into the queue.
  always_comb begin
    pair_t p;
    p           = split_pair(s3_q.mag[6:0]);
    push_o      = s3_v_q && !full_i;
    push_data_o = s3_q.frame;
    if (s3_q.is_num) begin
      push_data_o.d2 = seg_of(p.tens);
      push_data_o.d3 = seg_of(p.ones);
    end
  end

endmodule

### hw/rtl/sfg_queue.sv
module sfg_queue #(
  parameter int unsigned Depth = sfg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfg_pkg::frame_t data_i,
  input  logic            pop_i,
  output sfg_pkg::frame_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import sfg_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t          entries_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = entries_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

### hw/rtl/sfg_back.sv
module sfg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  sfg_pkg::frame_t               head_i,
  output logic                          pop_o,
  input  logic [sfg_pkg::BRIGHT_W-1:0]  brightness_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sfg_pkg::out_t                 out_o
);
  import sfg_pkg::*;

  `include "seven_segment_frame_generator_top_assert.svh"

  slot_e slot_q, slot_d;
  logic  out_valid_q, out_valid_d;
  out_t  out_q, byte_d;
  logic  load;

  // Next slot: one byte of the head frame moves to the output register
  // whenever that register is free or being drained and the queue is not empty.
  always_comb begin
    load   = (!out_valid_q || !out_stall_i) && !empty_i;
    slot_d = slot_q;
    pop_o  = 1'b0;
    if (load) begin
      if (slot_q == SLOT_DISP_CMD) begin
        slot_d = SLOT_DATA_CMD;
        pop_o  = 1'b1;
      end else begin
        slot_d = slot_e'(slot_q + 3'd1);
      end
    end
    out_valid_d = (!out_valid_q || !out_stall_i) ? !empty_i : out_valid_q;
  end

  always_comb begin
    byte_d = '0;
    case (slot_q)
      SLOT_DATA_CMD: byte_d = '{CMD_DATA, 1'b1, 1'b1, 1'b0};
      SLOT_ADDR_CMD: byte_d = '{CMD_ADDR, 1'b1, 1'b0, 1'b0};
      SLOT_DIG0:     byte_d = '{head_i.d0, 1'b0, 1'b0, 1'b0};
      SLOT_DIG1:     byte_d = '{head_i.d1, 1'b0, 1'b0, 1'b0};
      SLOT_DIG2:     byte_d = '{head_i.d2, 1'b0, 1'b0, 1'b0};
      SLOT_DIG3:     byte_d = '{head_i.d3, 1'b0, 1'b1, 1'b0};
      SLOT_DISP_CMD: byte_d = '{CMD_DISP | {5'b00000, brightness_i}, 1'b1, 1'b1, 1'b1};
      default:       byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SLOT_DATA_CMD;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SFG_ASSERT_IMPL(a_last_is_display_ctrl, out_valid_q && out_q.last_byte,
                   out_q.start_before && out_q.stop_after && out_q.tx_byte[7:3] == CMD_DISP[7:3])
  `SFG_ASSERT_IMPL(a_frame_end_rewinds, out_valid_q && out_q.last_byte,
                   slot_q == SLOT_DATA_CMD)
  `SFG_ASSERT_IMPL(a_addr_cmd_opens_digits,
                   out_valid_q && out_q.start_before && !out_q.stop_after,
                   out_q.tx_byte == CMD_ADDR)

endmodule

### hw/rtl/seven_segment_frame_generator_top.sv
// Seven-segment frame generator for a four-digit display controller.
// Input channel (in_valid_i / in_stall_o): one command per transfer, chosen
// by action_i: show number, show time, clear, or a tick.
// Output channel (out_valid_o / out_stall_i): one controller byte per
// transfer with its start, stop and last-byte marks. A display update is
// seven bytes; commands that change nothing on the display give none.
// A command's frame passes the three front stages (s1, s2, s3), the
// frame queue and the output register before its first byte is offered.
// The output gives one byte per cycle while out_stall_i is low; a
// displaying command gives seven bytes. Commands can be taken every cycle
// while the frame queue has room, and silent commands give no frame.
// The config port (cfg_we_i, cfg_index_i, cfg_wdata_i) sets brightness
// (index 0) and the refresh period in ticks (index 1); the user writes it while idle, not enforced by the block.
// Reset clears the stored time, the tick count and all queued frames and
// restores brightness 7 and a refresh period of 1000.
// A stalled receiver holds the current byte; the queue then fills and the
// input side stalls in turn.
module seven_segment_frame_generator_top #(
  parameter int unsigned QueueDepth = sfg_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic signed [15:0]              number_value_i,
  input  logic [7:0]                      hour_value_i,
  input  logic [7:0]                      minute_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      tx_byte_o,
  output logic                            start_before_o,
  output logic                            stop_after_o,
  output logic                            last_byte_o,
  input  logic                            cfg_we_i,
  input  logic [sfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import sfg_pkg::*;

  logic [BRIGHT_W-1:0]  brightness_q;
  logic [REFRESH_W-1:0] refresh_q;

  logic   push, pop, full, empty;
  frame_t push_data, head;
  out_t   out_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHT_RESET;
      refresh_q    <= REFRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BRIGHTNESS: brightness_q <= cfg_wdata_i[BRIGHT_W-1:0];
        REG_REFRESH:    refresh_q    <= cfg_wdata_i[REFRESH_W-1:0];
        default:        brightness_q <= brightness_q;
      endcase
    end
  end

  sfg_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .number_value_i   (number_value_i),
    .hour_value_i     (hour_value_i),
    .minute_value_i   (minute_value_i),
    .refresh_period_i (refresh_q),
    .full_i           (full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  sfg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  sfg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .brightness_i (brightness_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_byte)
  );

  assign tx_byte_o      = out_byte.tx_byte;
  assign start_before_o = out_byte.start_before;
  assign stop_after_o   = out_byte.stop_after;
  assign last_byte_o    = out_byte.last_byte;

endmodule
